>>> rtl/core/assert_macros.svh
// Assertion macros shared by the timestamp validator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk_i, held off while rst_ni is low.
`define TSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TSV_ASSERT_IMPL(label, ante, cons, msg) \
  `TSV_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/core/tsv_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the timestamp string validator.
package tsv_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned FieldW = 7;
  localparam int unsigned PosW   = 5;

  // Character positions in YYYYMMDDhhmm.ss
  localparam logic [PosW-1:0] PosYearLo   = 5'd2;
  localparam logic [PosW-1:0] PosMonth    = 5'd4;
  localparam logic [PosW-1:0] PosDay      = 5'd6;
  localparam logic [PosW-1:0] PosHour     = 5'd8;
  localparam logic [PosW-1:0] PosMinute   = 5'd10;
  localparam logic [PosW-1:0] PosMinLast  = 5'd11;
  localparam logic [PosW-1:0] PosDot      = 5'd12;
  localparam logic [PosW-1:0] PosSecLast  = 5'd14;
  localparam logic [PosW-1:0] PosEnd      = 5'd15;
  localparam logic [PosW-1:0] PosSat      = 5'd16;

  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChDot  = 8'h2E;

  localparam logic [FieldW-1:0] MonthMin   = 7'd1;
  localparam logic [FieldW-1:0] MonthFeb   = 7'd2;
  localparam logic [FieldW-1:0] MonthApr   = 7'd4;
  localparam logic [FieldW-1:0] MonthJun   = 7'd6;
  localparam logic [FieldW-1:0] MonthSep   = 7'd9;
  localparam logic [FieldW-1:0] MonthNov   = 7'd11;
  localparam logic [FieldW-1:0] MonthMax   = 7'd12;
  localparam logic [FieldW-1:0] DayMin     = 7'd1;
  localparam logic [FieldW-1:0] DaysFeb    = 7'd28;
  localparam logic [FieldW-1:0] DaysFebLp  = 7'd29;
  localparam logic [FieldW-1:0] DaysShort  = 7'd30;
  localparam logic [FieldW-1:0] DaysLong   = 7'd31;
  localparam logic [FieldW-1:0] HourMax    = 7'd23;
  localparam logic [FieldW-1:0] MinSecMax  = 7'd59;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
  } tsv_fields_t;

  // Length/format status plus the digit facts that decide the leap year
  typedef struct packed {
    logic       len_ok;
    logic       fmt_err;
    logic       lo_zero;   // last two year digits are both zero
    logic [1:0] hi_mod4;   // first two year digits, as a number, mod 4
  } tsv_status_t;

endpackage

>>> rtl/core/timestamp_string_validator.sv
`timescale 1ns / 1ps
// Top level of the timestamp string validator: input register, field logic, result register.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------------
//   in      | in_valid_i | in_stall_o  | char_in_i, last_char_i
//   out     | out_valid_o| out_stall_i | valid_res_o, year_out_o .. second_out_o
//
// One character is taken per cycle, back to back, while no last character waits
// behind a stalled result; the rate is set by the single accumulate-and-check step
// between the input register and the result register. A result is loaded into the
// result register when the marked last character leaves the input register.
// Reset clears the position, error flag and field accumulators; no clearing pass.
// A stalled result holds in the output register while plain characters keep
// flowing; only a second last character waits behind a stalled result.
`include "assert_macros.svh"

module timestamp_string_validator import tsv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        char_in_i,
  input  logic              last_char_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              valid_res_o,
  output logic [YearW-1:0]  year_out_o,
  output logic [FieldW-1:0] month_out_o,
  output logic [FieldW-1:0] day_out_o,
  output logic [FieldW-1:0] hour_out_o,
  output logic [FieldW-1:0] minute_out_o,
  output logic [FieldW-1:0] second_out_o
);

  // Input register
  logic        s1_valid_q;
  logic [7:0]  s1_char_q;
  logic        s1_last_q;

  // Result register
  logic        out_valid_q;
  logic        res_ok_q;
  tsv_fields_t res_q;

  logic        out_free;
  logic        s1_fire;
  logic        in_xfer;
  tsv_fields_t fields;
  tsv_status_t status;
  logic        ok;

  // The result register can take a new result when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  // Plain characters always advance; a last character needs room for its result
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the character payload on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_char_q <= char_in_i;
      s1_last_q <= last_char_i;
    end
  end

  tsv_field_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .char_i   (s1_char_q),
    .last_i   (s1_last_q),
    .fields_o (fields),
    .status_o (status)
  );

  tsv_date_check u_check (
    .fields_i (fields),
    .status_i (status),
    .ok_o     (ok)
  );

  // Load a result on a last character, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      res_ok_q <= ok;
      res_q    <= fields;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign valid_res_o  = res_ok_q;
  assign year_out_o   = res_q.year;
  assign month_out_o  = res_q.month;
  assign day_out_o    = res_q.day;
  assign hour_out_o   = res_q.hour;
  assign minute_out_o = res_q.minute;
  assign second_out_o = res_q.second;

  `TSV_ASSERT_IMPL(a_plain_char_advances, s1_valid_q && !s1_last_q, s1_fire,
                   "plain character held in the input register")
  `TSV_ASSERT_IMPL(a_stall_only_on_full_result, in_stall_o,
                   s1_last_q && out_valid_q && out_stall_i,
                   "input stalled without a stalled result ahead")
  `TSV_ASSERT(a_result_from_last_char, $rose(out_valid_q) |-> $past(s1_fire && s1_last_q),
              "result appeared without a last character")
  `TSV_ASSERT_IMPL(a_valid_result_in_range, out_valid_q && res_ok_q,
                   (res_q.month >= MonthMin) && (res_q.month <= MonthMax) &&
                   (res_q.day >= DayMin) && (res_q.hour <= HourMax),
                   "valid result carries an out-of-range field")

endmodule

>>> rtl/core/tsv_field_acc.sv
`timescale 1ns / 1ps
// Per-character field accumulator and format state of the timestamp validator.
module tsv_field_acc import tsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  char_i,
  input  logic        last_i,
  output tsv_fields_t fields_o,
  output tsv_status_t status_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic            err_q, err_d;
  logic            lo_zero_q, lo_zero_d;
  logic [1:0]      hi_mod4_q, hi_mod4_d;
  tsv_fields_t     acc_q, acc_d;
  logic            is_digit;
  logic [3:0]      digit;

  function automatic logic [FieldW-1:0] push_field(input logic [FieldW-1:0] acc,
                                                   input logic [3:0] d);
    logic [FieldW+3:0] wide;
    logic [FieldW+3:0] sum;
    wide = {4'b0000, acc};
    sum  = (wide << 3) + (wide << 1) + (FieldW+4)'(d);
    return sum[FieldW-1:0];
  endfunction

  function automatic logic [YearW-1:0] push_year(input logic [YearW-1:0] acc,
                                                 input logic [3:0] d);
    logic [YearW+3:0] wide;
    logic [YearW+3:0] sum;
    wide = {4'b0000, acc};
    sum  = (wide << 3) + (wide << 1) + (YearW+4)'(d);
    return sum[YearW-1:0];
  endfunction

  always_comb begin
    is_digit  = (char_i >= ChZero) && (char_i <= ChNine);
    digit     = is_digit ? 4'(char_i - ChZero) : 4'd0;
    acc_d     = acc_q;
    err_d     = err_q;
    lo_zero_d = lo_zero_q;
    hi_mod4_d = hi_mod4_q;
    if (pos_q < PosEnd) begin
      if (pos_q == PosDot) begin
        if (!is_digit && (char_i != ChDot)) begin
          err_d = 1'b1;
        end
      end else if (!is_digit) begin
        err_d = 1'b1;
      end else if (pos_q < PosMonth) begin
        acc_d.year = push_year(acc_q.year, digit);
        if (pos_q < PosYearLo) begin
          // (10h + d) mod 4 == (2h + d) mod 4
          hi_mod4_d = {hi_mod4_q[0], 1'b0} + digit[1:0];
        end else begin
          lo_zero_d = ((pos_q == PosYearLo) || lo_zero_q) && (digit == 4'd0);
        end
      end else if (pos_q < PosDay) begin
        acc_d.month = push_field(acc_q.month, digit);
      end else if (pos_q < PosHour) begin
        acc_d.day = push_field(acc_q.day, digit);
      end else if (pos_q < PosMinute) begin
        acc_d.hour = push_field(acc_q.hour, digit);
      end else if (pos_q < PosDot) begin
        acc_d.minute = push_field(acc_q.minute, digit);
      end else begin
        acc_d.second = push_field(acc_q.second, digit);
      end
    end
    pos_d = (pos_q < PosSat) ? pos_q + 5'd1 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      err_q     <= 1'b0;
      lo_zero_q <= 1'b0;
      hi_mod4_q <= '0;
      acc_q     <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q     <= '0;
        err_q     <= 1'b0;
        lo_zero_q <= 1'b0;
        hi_mod4_q <= '0;
        acc_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        err_q     <= err_d;
        lo_zero_q <= lo_zero_d;
        hi_mod4_q <= hi_mod4_d;
        acc_q     <= acc_d;
      end
    end
  end

  assign fields_o         = acc_d;
  assign status_o.len_ok  = (pos_q == PosMinLast) || (pos_q == PosSecLast);
  assign status_o.fmt_err = err_d;
  assign status_o.lo_zero = lo_zero_d;
  assign status_o.hi_mod4 = hi_mod4_d;

endmodule

>>> rtl/core/tsv_date_check.sv
`timescale 1ns / 1ps
// Calendar and clock range check of the parsed timestamp fields.
module tsv_date_check import tsv_pkg::*; (
  input  tsv_fields_t fields_i,
  input  tsv_status_t status_i,
  output logic        ok_o
);

  logic              leap;
  logic [FieldW-1:0] month_len;

  // Gregorian rule; year mod 4 is its low two bits, mod 100 and mod 400 come from the digits
  assign leap = ((fields_i.year[1:0] == 2'b00) && !status_i.lo_zero) ||
                (status_i.lo_zero && (status_i.hi_mod4 == 2'b00));

  always_comb begin
    case (fields_i.month)
      MonthFeb: month_len = leap ? DaysFebLp : DaysFeb;
      MonthApr, MonthJun, MonthSep, MonthNov: month_len = DaysShort;
      default: month_len = DaysLong;
    endcase
  end

  assign ok_o = status_i.len_ok && !status_i.fmt_err &&
                (fields_i.month >= MonthMin) && (fields_i.month <= MonthMax) &&
                (fields_i.day >= DayMin) && (fields_i.day <= month_len) &&
                (fields_i.hour <= HourMax) &&
                (fields_i.minute <= MinSecMax) &&
                (fields_i.second <= MinSecMax);

endmodule
